[rtl/tss_pkg.sv]
`timescale 1ns / 1ps

package tss_pkg;

    // Default sizes and fixed limits
    localparam int TABLE_ENTRIES_DEF  = 32;
    localparam int CHANNELS_DEF       = 128;
    localparam int MAX_RESULTS        = 32;
    localparam int MAX_CHANNEL_NUMBER = 125;
    localparam int CNT_W              = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        MODE_TICK          = 2'd0,
        MODE_INSERT        = 2'd1,
        MODE_CLEAR_CHANNEL = 2'd2,
        MODE_CLEAR_ALL     = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [31:0]        now_time;
        logic [6:0]         channel;
        logic [31:0]        plan_time;
        logic signed [31:0] plan_value;
        logic               interpolate;
    } cmd_item_t;

    typedef struct packed {
        logic [6:0]         out_channel;
        logic signed [31:0] out_value;
        logic               last;
    } upd_item_t;

    typedef struct packed {
        logic [6:0]         channel;
        logic [31:0]        due_time;
        logic signed [31:0] value;
    } slot_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INSERT,
        S_CLEAR,
        S_CHAN,
        S_SCAN,
        S_PREP,
        S_MUL,
        S_DIV,
        S_FIN,
        S_PUSH,
        S_FLUSH
    } seq_state_t;

endpackage

[rtl/tss_cmd_if.sv]
`timescale 1ns / 1ps

interface tss_cmd_if;
    import tss_pkg::*;

    logic      valid;
    logic      ready;
    cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/tss_upd_if.sv]
`timescale 1ns / 1ps

interface tss_upd_if;
    import tss_pkg::*;

    logic      valid;
    logic      ready;
    upd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/timed_setpoint_schedule.sv]
`timescale 1ns / 1ps

// Timed setpoint schedule. Command items insert a (channel, time, value) entry
// into the lowest free slot of the entry table, clear one channel, clear all,
// or tick with the current time; a tick sends one update item per planned
// channel that has a due entry, up to MAX_RESULTS items, channels in
// ascending order, with last set on the final update of the tick. The block
// takes one command at a time. An interpolated update uses one multiply and
// a 32-step radix-2 divider; the table scan reads the entry memory one slot
// per cycle. Update items wait in an output register, and the tick stalls
// while that register is full.
module timed_setpoint_schedule #(
    parameter int TABLE_ENTRIES = tss_pkg::TABLE_ENTRIES_DEF,
    parameter int CHANNELS      = tss_pkg::CHANNELS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tss_cmd_if.sink   cmd,
    tss_upd_if.source upd
);
    import tss_pkg::*;

    localparam int SW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    seq_state_t state_reg, state_next;

    // Control state
    logic [TABLE_ENTRIES-1:0] slot_valid_reg;
    logic [CHANNELS-1:0]      planned_reg;
    logic [CHANNELS-1:0]      interp_reg;
    logic [SW-1:0]            slot_idx_reg;
    logic                     issue_on_reg;
    logic                     eval_vld_reg;
    logic [SW-1:0]            eval_idx_reg;
    logic [CW-1:0]            chan_idx_reg;
    logic                     have_due_reg;
    logic                     have_next_reg;
    logic                     pend_vld_reg;
    logic                     out_vld_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [4:0]               step_reg;

    // Payload
    slot_entry_t              slot_mem [TABLE_ENTRIES];
    slot_entry_t              rd_reg;
    cmd_item_t                cmd_reg;
    logic [31:0]              due_time_reg;
    logic signed [31:0]       due_value_reg;
    logic [31:0]              next_time_reg;
    logic signed [31:0]       next_value_reg;
    logic                     neg_reg;
    logic [31:0]              mag_reg;
    logic [31:0]              dist_reg;
    logic [31:0]              span_reg;
    logic [31:0]              rem_reg;
    logic [31:0]              lo_reg;
    logic signed [31:0]       res_value_reg;
    upd_item_t                pend_reg;
    upd_item_t                out_reg;

    // Handshake and decode
    logic accept, out_free, out_load, eval_last, slot_last, chan_last, adv;
    logic ins_ok, clr_ok, hit, is_due, div_ge;
    logic signed [32:0] diff_w;
    logic [32:0]        trial_w;
    logic signed [33:0] sum_w;
    logic signed [31:0] sat_w;

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !out_vld_reg || upd.ready;
    assign upd.valid = out_vld_reg;
    assign upd.data  = out_reg;

    // Output register takes the pending item
    assign out_load  = ((state_reg == S_PUSH) && (cnt_reg != CNT_W'(MAX_RESULTS))
                        && pend_vld_reg && out_free)
                       || ((state_reg == S_FLUSH) && pend_vld_reg && out_free);

    assign eval_last = eval_vld_reg && (eval_idx_reg == SW'(TABLE_ENTRIES - 1));
    assign slot_last = (slot_idx_reg == SW'(TABLE_ENTRIES - 1));
    assign chan_last = (chan_idx_reg == CW'(CHANNELS - 1));
    assign ins_ok    = (cmd.data.channel <= 7'(MAX_CHANNEL_NUMBER))
                       && ({25'd0, cmd.data.channel} < 32'(CHANNELS));
    assign clr_ok    = ({25'd0, cmd.data.channel} < 32'(CHANNELS));

    // Entry match for the channel under scan
    assign hit    = slot_valid_reg[eval_idx_reg]
                    && (9'(rd_reg.channel) == 9'(chan_idx_reg));
    assign is_due = (rd_reg.due_time <= cmd_reg.now_time);

    // Interpolation arithmetic
    assign diff_w  = {next_value_reg[31], next_value_reg}
                     - {due_value_reg[31], due_value_reg};
    assign trial_w = {rem_reg, lo_reg[31]};
    assign div_ge  = (trial_w >= {1'b0, span_reg});
    assign sum_w   = neg_reg ? ({{2{due_value_reg[31]}}, due_value_reg} - {2'b00, lo_reg})
                             : ({{2{due_value_reg[31]}}, due_value_reg} + {2'b00, lo_reg});
    always_comb
    begin
        if (sum_w > 34'sh0_7FFF_FFFF)
            sat_w = 32'sh7FFF_FFFF;
        else if (sum_w < -34'sh0_8000_0000)
            sat_w = -32'sh8000_0000;
        else
            sat_w = sum_w[31:0];
    end

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        adv        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.data.mode)
                        MODE_TICK:          state_next = S_CHAN;
                        MODE_INSERT:        state_next = ins_ok ? S_INSERT : S_IDLE;
                        MODE_CLEAR_CHANNEL: state_next = clr_ok ? S_CLEAR : S_IDLE;
                        MODE_CLEAR_ALL:     state_next = S_IDLE;
                    endcase
                end
            end
            S_INSERT:
            begin
                if (!slot_valid_reg[slot_idx_reg] || slot_last)
                    state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                if (eval_last)
                    state_next = S_IDLE;
            end
            S_CHAN:
            begin
                if (planned_reg[chan_idx_reg])
                    state_next = S_SCAN;
                else
                    adv = 1'b1;
            end
            S_SCAN:
            begin
                if (eval_last)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                if (!have_due_reg)
                    adv = 1'b1;
                else if (interp_reg[chan_idx_reg] && have_next_reg)
                    state_next = S_MUL;
                else
                    state_next = S_PUSH;
            end
            S_MUL:   state_next = S_DIV;
            S_DIV:
            begin
                if (step_reg == 5'd31)
                    state_next = S_FIN;
            end
            S_FIN:   state_next = S_PUSH;
            S_PUSH:
            begin
                if (cnt_reg == CNT_W'(MAX_RESULTS) || !pend_vld_reg || out_free)
                    adv = 1'b1;
            end
            S_FLUSH:
            begin
                if (!pend_vld_reg || out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (adv)
            state_next = chan_last ? S_FLUSH : S_CHAN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            planned_reg    <= '0;
            interp_reg     <= '0;
            slot_idx_reg   <= '0;
            issue_on_reg   <= 1'b0;
            eval_vld_reg   <= 1'b0;
            eval_idx_reg   <= '0;
            chan_idx_reg   <= '0;
            have_due_reg   <= 1'b0;
            have_next_reg  <= 1'b0;
            pend_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
            cnt_reg        <= '0;
            step_reg       <= '0;
        end
        else
        begin
            eval_vld_reg <= issue_on_reg && (state_reg == S_SCAN || state_reg == S_CLEAR);
            eval_idx_reg <= slot_idx_reg;
            if (out_load)
                out_vld_reg <= 1'b1;
            else if (upd.ready)
                out_vld_reg <= 1'b0;

            // Slot address sweep
            if (issue_on_reg)
            begin
                if (slot_last)
                    issue_on_reg <= 1'b0;
                else
                    slot_idx_reg <= slot_idx_reg + SW'(1);
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        slot_idx_reg <= '0;
                        chan_idx_reg <= '0;
                        cnt_reg      <= '0;
                        unique case (cmd.data.mode)
                            MODE_TICK: ;
                            MODE_INSERT:
                            begin
                                if (ins_ok)
                                begin
                                    planned_reg[CW'(cmd.data.channel)] <= 1'b1;
                                    if (cmd.data.interpolate)
                                        interp_reg[CW'(cmd.data.channel)] <= 1'b1;
                                end
                            end
                            MODE_CLEAR_CHANNEL:
                            begin
                                if (clr_ok)
                                begin
                                    planned_reg[CW'(cmd.data.channel)] <= 1'b0;
                                    interp_reg[CW'(cmd.data.channel)]  <= 1'b0;
                                    issue_on_reg                       <= 1'b1;
                                end
                            end
                            MODE_CLEAR_ALL:
                            begin
                                slot_valid_reg <= '0;
                                planned_reg    <= '0;
                                interp_reg     <= '0;
                            end
                        endcase
                    end
                end
                S_INSERT:
                begin
                    if (!slot_valid_reg[slot_idx_reg])
                        slot_valid_reg[slot_idx_reg] <= 1'b1;
                    else if (!slot_last)
                        slot_idx_reg <= slot_idx_reg + SW'(1);
                end
                S_CLEAR:
                begin
                    if (eval_vld_reg && slot_valid_reg[eval_idx_reg]
                        && rd_reg.channel == cmd_reg.channel)
                        slot_valid_reg[eval_idx_reg] <= 1'b0;
                end
                S_CHAN:
                begin
                    if (planned_reg[chan_idx_reg])
                    begin
                        slot_idx_reg  <= '0;
                        issue_on_reg  <= 1'b1;
                        have_due_reg  <= 1'b0;
                        have_next_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    if (eval_vld_reg && hit)
                    begin
                        if (is_due)
                        begin
                            if (!have_due_reg || rd_reg.due_time > due_time_reg)
                                have_due_reg <= 1'b1;
                            if (!interp_reg[chan_idx_reg])
                                slot_valid_reg[eval_idx_reg] <= 1'b0;
                        end
                        else if (!have_next_reg || rd_reg.due_time < next_time_reg)
                            have_next_reg <= 1'b1;
                    end
                end
                S_MUL:  step_reg <= '0;
                S_DIV:  step_reg <= step_reg + 5'd1;
                S_PUSH:
                begin
                    if (cnt_reg != CNT_W'(MAX_RESULTS) && (!pend_vld_reg || out_free))
                    begin
                        cnt_reg      <= cnt_reg + CNT_W'(1);
                        pend_vld_reg <= 1'b1;
                    end
                end
                S_FLUSH:
                begin
                    if (pend_vld_reg && out_free)
                        pend_vld_reg <= 1'b0;
                end
                default: ;
            endcase

            if (adv)
                chan_idx_reg <= chan_idx_reg + CW'(1);
        end
    end

    // Entry memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        rd_reg <= slot_mem[slot_idx_reg];
        if (state_reg == S_INSERT && !slot_valid_reg[slot_idx_reg])
            slot_mem[slot_idx_reg] <= '{channel:  cmd_reg.channel,
                                        due_time: cmd_reg.plan_time,
                                        value:    cmd_reg.plan_value};
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd.data;

        // Latest due and earliest future entry of the channel
        if (state_reg == S_SCAN && eval_vld_reg && hit)
        begin
            if (is_due)
            begin
                if (!have_due_reg || rd_reg.due_time > due_time_reg)
                begin
                    due_time_reg  <= rd_reg.due_time;
                    due_value_reg <= rd_reg.value;
                end
            end
            else if (!have_next_reg || rd_reg.due_time < next_time_reg)
            begin
                next_time_reg  <= rd_reg.due_time;
                next_value_reg <= rd_reg.value;
            end
        end

        unique case (state_reg)
            S_PREP:
            begin
                neg_reg       <= diff_w[32];
                mag_reg       <= diff_w[32] ? 32'(-diff_w) : diff_w[31:0];
                dist_reg      <= cmd_reg.now_time - due_time_reg;
                span_reg      <= next_time_reg - due_time_reg;
                res_value_reg <= due_value_reg;
            end
            S_MUL:
                {rem_reg, lo_reg} <= 64'(mag_reg) * 64'(dist_reg);
            S_DIV:
            begin
                // Restoring divide, quotient shifts into the low word
                rem_reg <= div_ge ? 32'(trial_w - {1'b0, span_reg}) : trial_w[31:0];
                lo_reg  <= {lo_reg[30:0], div_ge};
            end
            S_FIN:
                res_value_reg <= sat_w;
            S_PUSH:
            begin
                if (cnt_reg != CNT_W'(MAX_RESULTS) && (!pend_vld_reg || out_free))
                begin
                    pend_reg <= '{out_channel: 7'(chan_idx_reg),
                                  out_value:   res_value_reg,
                                  last:        1'b0};
                    if (pend_vld_reg)
                        out_reg <= pend_reg;
                end
            end
            S_FLUSH:
            begin
                if (pend_vld_reg && out_free)
                    out_reg <= '{out_channel: pend_reg.out_channel,
                                 out_value:   pend_reg.out_value,
                                 last:        1'b1};
            end
            default: ;
        endcase
    end

    // Checks
    a_div_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < span_reg))
        else $error("divider remainder not below span");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_vld_reg)
        else $error("update left pending after tick");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("update count beyond limit");

    a_eval_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && eval_vld_reg) |-> $past(issue_on_reg))
        else $error("slot evaluated without a read issued");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import tss_pkg::*;

    localparam int SLOTS      = 32;
    localparam int NUM_CHAN   = 128;
    localparam int RAND_ITEMS = 115;
    localparam int DRAIN_WAIT = 4000;
    localparam int CYCLE_CAP  = 5000000;

    typedef struct {
        cmd_item_t          c;
        bit                 has_exp;
        logic [6:0]         exp_chan;
        logic signed [31:0] exp_val;
    } stim_row_t;

    logic clk;
    logic rst_n;

    tss_cmd_if cmd ();
    tss_upd_if upd ();

    timed_setpoint_schedule u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .upd   (upd)
    );

    // Shadow copy of the schedule table
    bit                 tbl_used [SLOTS];
    logic [6:0]         tbl_chan [SLOTS];
    logic [31:0]        tbl_time [SLOTS];
    logic signed [31:0] tbl_val  [SLOTS];
    bit                 ch_planned [NUM_CHAN];
    bit                 ch_interp  [NUM_CHAN];

    upd_item_t pending_upd[$];
    stim_row_t rows[$];
    int        err_cnt;
    int        cycles;
    int        sent_cnt;
    int        stall_left;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Linear interpolation in Q16.16, increment truncated toward zero, then saturated
    function automatic logic signed [31:0] lerp_q16(logic signed [31:0] v0,
                                                    logic signed [31:0] v1,
                                                    logic [31:0] t0, logic [31:0] t1,
                                                    logic [31:0] now);
        longint          diff;
        longint unsigned mag, dt, span, q;
        longint          r;
        logic [31:0]     dt32, span32;
        diff   = longint'(v1) - longint'(v0);
        mag    = (diff < 0) ? longint'(-diff) : diff;
        dt32   = now - t0;
        span32 = t1 - t0;
        dt     = {32'd0, dt32};
        span   = {32'd0, span32};
        if (span == 0)
            return v0;
        q = (mag * dt) / span;
        r = (diff < 0) ? longint'(v0) - longint'(q) : longint'(v0) + longint'(q);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    // Apply one command to the shadow table; updates a tick causes go to outq
    task automatic schedule_apply(input cmd_item_t c, ref upd_item_t outq[$]);
        bit        have_due, have_next;
        int        due, nxt;
        logic signed [31:0] v;
        upd_item_t u;
        case (c.mode)
            MODE_INSERT:
            begin
                if (c.channel <= MAX_CHANNEL_NUMBER)
                begin
                    ch_planned[c.channel] = 1'b1;
                    if (c.interpolate)
                        ch_interp[c.channel] = 1'b1;
                    for (int j = 0; j < SLOTS; j++)
                    begin
                        if (!tbl_used[j])
                        begin
                            tbl_used[j] = 1'b1;
                            tbl_chan[j] = c.channel;
                            tbl_time[j] = c.plan_time;
                            tbl_val[j]  = c.plan_value;
                            break;
                        end
                    end
                end
            end
            MODE_CLEAR_CHANNEL:
            begin
                for (int j = 0; j < SLOTS; j++)
                    if (tbl_used[j] && tbl_chan[j] == c.channel)
                        tbl_used[j] = 1'b0;
                ch_planned[c.channel] = 1'b0;
                ch_interp[c.channel]  = 1'b0;
            end
            MODE_CLEAR_ALL:
            begin
                for (int j = 0; j < SLOTS; j++)
                    tbl_used[j] = 1'b0;
                for (int i = 0; i < NUM_CHAN; i++)
                begin
                    ch_planned[i] = 1'b0;
                    ch_interp[i]  = 1'b0;
                end
            end
            default:
            begin
                for (int i = 0; i < NUM_CHAN; i++)
                begin
                    if (!ch_planned[i])
                        continue;
                    have_due  = 1'b0;
                    have_next = 1'b0;
                    due = 0;
                    nxt = 0;
                    for (int j = 0; j < SLOTS; j++)
                    begin
                        if (!tbl_used[j] || tbl_chan[j] != i)
                            continue;
                        if (tbl_time[j] <= c.now_time)
                        begin
                            if (!have_due || tbl_time[j] > tbl_time[due])
                            begin
                                due = j;
                                have_due = 1'b1;
                            end
                        end
                        else if (!have_next || tbl_time[j] < tbl_time[nxt])
                        begin
                            nxt = j;
                            have_next = 1'b1;
                        end
                    end
                    if (!have_due)
                        continue;
                    if (ch_interp[i] && have_next)
                        v = lerp_q16(tbl_val[due], tbl_val[nxt], tbl_time[due],
                                     tbl_time[nxt], c.now_time);
                    else
                        v = tbl_val[due];
                    // Plain channels consume their due entries
                    if (!ch_interp[i])
                        for (int j = 0; j < SLOTS; j++)
                            if (tbl_used[j] && tbl_chan[j] == i && tbl_time[j] <= c.now_time)
                                tbl_used[j] = 1'b0;
                    if (outq.size() < MAX_RESULTS)
                    begin
                        u.out_channel = i[6:0];
                        u.out_value   = v;
                        u.last        = 1'b0;
                        outq.push_back(u);
                    end
                end
                if (outq.size() > 0)
                    outq[outq.size() - 1].last = 1'b1;
            end
        endcase
    endtask

    function automatic cmd_item_t make_cmd(mode_t m, logic [31:0] now, logic [6:0] ch,
                                           logic [31:0] pt, logic [31:0] pv, bit ip);
        cmd_item_t c;
        c.mode        = m;
        c.now_time    = now;
        c.channel     = ch;
        c.plan_time   = pt;
        c.plan_value  = pv;
        c.interpolate = ip;
        return c;
    endfunction

    task automatic add_row(cmd_item_t c, bit he = 0, logic [6:0] ec = '0,
                           logic [31:0] ev = '0);
        stim_row_t r;
        r.c        = c;
        r.has_exp  = he;
        r.exp_chan = ec;
        r.exp_val  = ev;
        rows.push_back(r);
    endtask

    // Present one item after a random gap, zero in alternate runs of 40, until taken
    task automatic send_item(stim_row_t r);
        int        gap;
        upd_item_t fresh[$];
        gap = ((sent_cnt / 40) % 2 == 1) ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.data  <= r.c;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        schedule_apply(r.c, fresh);
        if (r.has_exp)
        begin
            fresh.delete();
            fresh.push_back('{out_channel: r.exp_chan, out_value: r.exp_val, last: 1'b1});
        end
        foreach (fresh[k])
            pending_upd.push_back(fresh[k]);
        sent_cnt++;
    endtask

    task automatic wait_drained();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pending_upd.size() != 0)
            @(posedge clk);
    endtask

    // Update receiver: random back-pressure and in-order check
    always @(posedge clk)
    begin
        upd_item_t want;
        if (upd.valid && upd.ready)
        begin
            if (pending_upd.size() == 0)
            begin
                $display("%0t: unexpected update ch=%0d val=%h last=%0b", $time,
                         upd.data.out_channel, upd.data.out_value, upd.data.last);
                err_cnt++;
            end
            else
            begin
                want = pending_upd.pop_front();
                if (upd.data !== want)
                begin
                    $display("%0t: update mismatch expected ch=%0d val=%h last=%0b, got ch=%0d val=%h last=%0b",
                             $time, want.out_channel, want.out_value, want.last,
                             upd.data.out_channel, upd.data.out_value, upd.data.last);
                    err_cnt++;
                end
            end
            stall_left = ((cycles / 700) % 3 == 0) ? 0 : $urandom_range(0, 7);
        end
        else if (stall_left > 0)
            stall_left--;
        upd.ready <= (stall_left == 0);
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        cmd_item_t   c;
        stim_row_t   r;
        int          sel;
        logic [31:0] clock_now;
        logic [6:0]  ch;
        err_cnt    = 0;
        cycles     = 0;
        sent_cnt   = 0;
        stall_left = 0;
        clock_now  = 32'd100;
        rst_n      = 1'b0;
        cmd.valid  = 1'b0;
        cmd.data   = '0;
        upd.ready  = 1'b0;
        for (int j = 0; j < SLOTS; j++)
            tbl_used[j] = 1'b0;
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            ch_planned[i] = 1'b0;
            ch_interp[i]  = 1'b0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: extremes, ignored channels, interpolation, equal times
        add_row(make_cmd(MODE_TICK, 32'd0, 7'd0, 32'd0, 32'd0, 1'b0));
        add_row(make_cmd(MODE_INSERT, 32'd0, 7'd0, 32'd0, 32'h7FFF_FFFF, 1'b0));
        add_row(make_cmd(MODE_TICK, 32'd0, 7'd0, 32'd0, 32'd0, 1'b0), 1, 7'd0, 32'h7FFF_FFFF);
        add_row(make_cmd(MODE_INSERT, 32'd0, 7'd125, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1));
        add_row(make_cmd(MODE_INSERT, 32'd0, 7'd126, 32'd0, 32'd1, 1'b1));
        add_row(make_cmd(MODE_INSERT, 32'd0, 7'd127, 32'd0, 32'd2, 1'b1));
        add_row(make_cmd(MODE_INSERT, 32'd0, 7'd125, 32'd0, 32'd0, 1'b0));
        add_row(make_cmd(MODE_TICK, 32'hFFFF_FFFF, 7'd0, 32'd0, 32'd0, 1'b0), 1, 7'd125,
                32'h8000_0000);
        add_row(make_cmd(MODE_CLEAR_ALL, 32'd0, 7'd0, 32'd0, 32'd0, 1'b0));
        add_row(make_cmd(MODE_INSERT, 32'd0, 7'd3, 32'd10, -32'sd100, 1'b1));
        add_row(make_cmd(MODE_INSERT, 32'd0, 7'd3, 32'd20, 32'sd100, 1'b0));
        add_row(make_cmd(MODE_TICK, 32'd15, 7'd0, 32'd0, 32'd0, 1'b0), 1, 7'd3, 32'd0);
        add_row(make_cmd(MODE_INSERT, 32'd0, 7'd3, 32'd10, 32'sd5, 1'b0));
        add_row(make_cmd(MODE_TICK, 32'd12, 7'd0, 32'd0, 32'd0, 1'b0));
        add_row(make_cmd(MODE_TICK, 32'd25, 7'd0, 32'd0, 32'd0, 1'b0));
        add_row(make_cmd(MODE_CLEAR_CHANNEL, 32'd0, 7'd3, 32'd0, 32'd0, 1'b0));
        add_row(make_cmd(MODE_CLEAR_CHANNEL, 32'd0, 7'd127, 32'd0, 32'd0, 1'b0));
        add_row(make_cmd(MODE_INSERT, 32'd0, 7'd5, 32'd0, 32'h8000_0000, 1'b1));
        add_row(make_cmd(MODE_INSERT, 32'd0, 7'd5, 32'd2, 32'h7FFF_FFFF, 1'b0));
        add_row(make_cmd(MODE_INSERT, 32'd0, 7'd6, 32'd0, 32'h7FFF_FFFF, 1'b1));
        add_row(make_cmd(MODE_INSERT, 32'd0, 7'd6, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1));
        add_row(make_cmd(MODE_TICK, 32'd1, 7'd0, 32'd0, 32'd0, 1'b0));
        add_row(make_cmd(MODE_TICK, 32'hFFFF_FFFE, 7'd0, 32'd0, 32'd0, 1'b0));
        add_row(make_cmd(MODE_CLEAR_ALL, 32'd0, 7'd0, 32'd0, 32'd0, 1'b0));
        add_row(make_cmd(MODE_TICK, 32'hFFFF_FFFF, 7'd0, 32'd0, 32'd0, 1'b0));
        foreach (rows[k])
            send_item(rows[k]);
        wait_drained();

        // Random part: mostly inserts on a few channels so the table fills
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            sel = $urandom_range(0, 99);
            ch  = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, 7) ^ 7'h78 * $urandom_range(0, 1));
            if (sel < 60)
                c = make_cmd(MODE_INSERT, $urandom, ch,
                             ($urandom_range(0, 7) == 0) ? $urandom
                                                         : clock_now + $urandom_range(0, 40) - 8,
                             $urandom, $urandom_range(0, 1));
            else if (sel < 87)
            begin
                clock_now += $urandom_range(0, 15);
                c = make_cmd(MODE_TICK, ($urandom_range(0, 9) == 0) ? $urandom : clock_now,
                             7'($urandom), $urandom, $urandom, $urandom_range(0, 1));
            end
            else if (sel < 96)
                c = make_cmd(MODE_CLEAR_CHANNEL, $urandom, ch, $urandom, $urandom,
                             $urandom_range(0, 1));
            else
                c = make_cmd(MODE_CLEAR_ALL, $urandom, 7'($urandom), $urandom, $urandom,
                             $urandom_range(0, 1));
            r.c       = c;
            r.has_exp = 1'b0;
            send_item(r);
            if (n == RAND_ITEMS / 2)
                wait_drained();
        end
        cmd.valid <= 1'b0;

        while (pending_upd.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
rtl/tss_pkg.sv
rtl/tss_cmd_if.sv
rtl/tss_upd_if.sv
rtl/timed_setpoint_schedule.sv
test/tb_top.sv
